// ----- rtl/ibe_pkg.sv -----
// Shared types and constants for the x86-64 instruction byte emitter.
// Used by ibe_front, ibe_back and the top level; depends on nothing.
package ibe_pkg;

    localparam logic [7:0] OPSIZE_PREFIX   = 8'h66;
    localparam logic [7:0] ADDRSIZE_PREFIX = 8'h67;
    localparam logic [3:0] REX_BASE_HI     = 4'h4;

    localparam int unsigned NUM_PARTS   = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] PART_OPSIZE   = 3'd0;
    localparam logic [2:0] PART_ADDRSIZE = 3'd1;
    localparam logic [2:0] PART_REX      = 3'd2;
    localparam logic [2:0] PART_OPCODE   = 3'd3;
    localparam logic [2:0] PART_MODRM    = 3'd4;
    localparam logic [2:0] PART_SIB      = 3'd5;
    localparam logic [2:0] PART_DISP     = 3'd6;
    localparam logic [2:0] PART_IMM      = 3'd7;

    typedef struct packed {
        logic [5:0]         present_mask;
        logic [3:0]         rex_bits;
        logic [7:0]         opcode_byte;
        logic [7:0]         modrm_fields;
        logic [7:0]         sib_fields;
        logic [2:0]         disp_len;
        logic signed [31:0] disp_value;
        logic [2:0]         imm_len;
        logic signed [31:0] imm_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [NUM_PARTS-1:0] parts;
        logic [3:0]           rex_bits;
        logic [7:0]           opcode_byte;
        logic [7:0]           modrm_fields;
        logic [7:0]           sib_fields;
        logic [2:0]           disp_len;
        logic [31:0]          disp_value;
        logic [2:0]           imm_len;
        logic [31:0]          imm_value;
    } entry_t;

endpackage

// ----- rtl/x86_64_instruction_byte_emitter_top.sv -----
// Top level of the x86-64 instruction byte emitter.
// Instantiates ibe_front and ibe_back; depends on ibe_pkg.
//
// Each accepted instruction description produces its machine-code bytes one per
// clock cycle while popped, in encoding order, with the final byte marked by
// last_byte. An instruction of N bytes (1 to 20) occupies the byte sequencer until
// its last byte is emitted; one with no parts produces nothing and costs no
// sequencer time. The sequencer's one-byte-per-cycle output path sets the rate. A
// two-entry queue in front of the sequencer accepts new instructions while earlier
// ones are still emitted, and an output register holds the current byte until popped.
module x86_64_instruction_byte_emitter_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ibe_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output ibe_pkg::out_item_t  result
);

    logic            head_valid;
    ibe_pkg::entry_t head;
    logic            head_pop;

    ibe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    ibe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- rtl/ibe_front.sv -----
// Front end of the emitter: accepts instruction descriptions, classifies their parts
// and holds them in a two-entry queue. Depends on ibe_pkg.
module ibe_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ibe_pkg::in_item_t   item,
    output logic                head_valid,
    output ibe_pkg::entry_t     head,
    input  logic                head_pop
);

    ibe_pkg::entry_t entries_reg [ibe_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    ibe_pkg::entry_t classified;
    logic            accept;
    logic            write_en;
    logic            pop_en;

    always_comb
    begin
        classified.parts        = {(item.imm_len != 3'd0), (item.disp_len != 3'd0),
                                   item.present_mask};
        classified.rex_bits     = item.rex_bits;
        classified.opcode_byte  = item.opcode_byte;
        classified.modrm_fields = item.modrm_fields;
        classified.sib_fields   = item.sib_fields;
        classified.disp_len     = item.disp_len;
        classified.disp_value   = item.disp_value;
        classified.imm_len      = item.imm_len;
        classified.imm_value    = item.imm_value;
    end

    assign full       = (count_reg == 2'(ibe_pkg::QUEUE_DEPTH));
    assign accept     = push && !full;
    // An instruction with no parts produces no bytes and is dropped here.
    assign write_en   = accept && (classified.parts != '0);
    assign head_valid = (count_reg != 2'd0);
    assign pop_en     = head_pop && head_valid;
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = write_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (write_en && !pop_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_en && !write_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            entries_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(ibe_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_empty_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && classified.parts == '0 && !pop_en) |=> $stable(count_reg))
        else $error("empty instruction entered the queue");

    a_ptr_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/ibe_back.sv -----
// Back end of the emitter: walks the parts of the queue head and emits one byte
// per cycle into an output register while it is empty or popped. Depends on ibe_pkg.
module ibe_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ibe_pkg::entry_t     head,
    output logic                head_pop,
    output logic                empty,
    input  logic                pop,
    output ibe_pkg::out_item_t  result
);

    logic [ibe_pkg::NUM_PARTS-1:0] taken_reg;
    logic [ibe_pkg::NUM_PARTS-1:0] taken_next;
    logic [2:0]                    cnt_reg;
    logic [2:0]                    cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ibe_pkg::out_item_t            out_reg;
    ibe_pkg::out_item_t            out_next;
    logic [ibe_pkg::NUM_PARTS-1:0] remaining;
    logic [ibe_pkg::NUM_PARTS-1:0] sel_mask;
    logic [2:0]                    sel;
    logic                          multi;
    logic [2:0]                    cur_len;
    logic [31:0]                   cur_val;
    logic [7:0]                    val_byte;
    logic [7:0]                    code;
    logic                          part_done;
    logic                          last;
    logic                          emit;

    assign remaining = head.parts & ~taken_reg;

    always_comb
    begin
        sel = ibe_pkg::PART_OPSIZE;
        for (int i = ibe_pkg::NUM_PARTS - 1; i >= 0; i--)
        begin
            if (remaining[i])
            begin
                sel = 3'(i);
            end
        end
    end

    assign sel_mask = 8'd1 << sel;
    assign multi    = (sel == ibe_pkg::PART_DISP) || (sel == ibe_pkg::PART_IMM);
    assign cur_len  = (sel == ibe_pkg::PART_DISP) ? head.disp_len : head.imm_len;
    assign cur_val  = (sel == ibe_pkg::PART_DISP) ? head.disp_value : head.imm_value;
    assign val_byte = cnt_reg[2] ? {8{cur_val[31]}} : cur_val[cnt_reg[1:0]*8 +: 8];

    always_comb
    begin
        case (sel)
            ibe_pkg::PART_OPSIZE:   code = ibe_pkg::OPSIZE_PREFIX;
            ibe_pkg::PART_ADDRSIZE: code = ibe_pkg::ADDRSIZE_PREFIX;
            ibe_pkg::PART_REX:      code = {ibe_pkg::REX_BASE_HI, head.rex_bits};
            ibe_pkg::PART_OPCODE:   code = head.opcode_byte;
            ibe_pkg::PART_MODRM:    code = head.modrm_fields;
            ibe_pkg::PART_SIB:      code = head.sib_fields;
            default:                code = val_byte;
        endcase
    end

    assign part_done = !multi || (cnt_reg == cur_len - 3'd1);
    assign last      = part_done && ((remaining & ~sel_mask) == '0);
    assign emit      = head_valid && (!out_valid_reg || pop);
    assign head_pop  = emit && last;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        taken_next     = taken_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next     = 1'b1;
            out_next.code_byte = code;
            out_next.last_byte = last;
            if (!part_done)
            begin
                cnt_next = cnt_reg + 3'd1;
            end
            else
            begin
                cnt_next   = 3'd0;
                taken_next = last ? '0 : (taken_reg | sel_mask);
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg     <= '0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            taken_reg     <= taken_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> (taken_reg == '0 && cnt_reg == 3'd0))
        else $error("sequencer not cleared after final byte");

    a_cnt_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 3'd0) |-> (head_valid && multi))
        else $error("byte counter active outside displacement or immediate");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (taken_reg == '0))
        else $error("parts marked taken without a queued instruction");

    a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && out_reg.last_byte == $past(last)))
        else $error("emitted byte did not reach the output register");
`endif

endmodule
